### hw/rtl/assert_macros.svh
// assertion macros used by the top level rtl file of the index transpose block
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, switched off while reset is low
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never be true
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond))

`endif

### hw/rtl/ndlit_pkg.sv
// shared types and constants of the nd array index transpose block
// used by ndlit_cfg_regs, ndlit_divider and the top level; no dependencies
package ndlit_pkg;

  localparam int unsigned ExtentRegs = 4;
  localparam int unsigned ExtentW    = 16;
  localparam int unsigned DimCountW  = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned FieldW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIM_COUNT       = 3'd0,
    REG_EXTENT_0        = 3'd1,
    REG_EXTENT_1        = 3'd2,
    REG_EXTENT_2        = 3'd3,
    REG_EXTENT_3        = 3'd4,
    REG_TO_COLUMN_MAJOR = 3'd5,
    REG_ELEMENT_COUNT   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [DimCountW-1:0]                dim_count;
    logic [ExtentRegs-1:0][ExtentW-1:0]  extent;
    logic                                to_column_major;
    logic [FieldW-1:0]                   element_count;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } seq_state_e;

endpackage

### hw/rtl/nd_array_layout_index_transpose_unit.sv
// top level of the nd array layout index transpose unit: sequencer and datapath
// depends on ndlit_pkg, ndlit_cfg_regs, ndlit_divider and assert_macros.svh
//
//  channel   | direction | tdata                 | tlast        | tuser
//  ----------+-----------+-----------------------+--------------+-------------
//  s_axis    | in        | dest_index [31:0]     | -            | -
//  m_axis    | out       | source_index [31:0]   | last_element | out_of_range
//  cfg       | in        | write only: cfg_we_i, cfg_idx_i, cfg_data_i
//
// for each dimension in use the sequencer runs a setup step and a divide step,
// then loads the result into the output register and returns to idle to take the
// next input; W = min(INDEX_WIDTH, 32) is the divider width, and the shared serial
// divider gives one quotient bit a cycle
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register so the next input can be taken meanwhile
// asynchronous active-low reset clears control state and sets the configuration to its defaults
`include "assert_macros.svh"

module nd_array_layout_index_transpose_unit #(
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [ndlit_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ndlit_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // [31:0] dest_index
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,   // [31:0] source_index
  output logic                           m_axis_tlast,   // last_element
  output logic                           m_axis_tuser    // [0] out_of_range
);

  localparam int unsigned CalcW = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;
  localparam int unsigned DimW  = $clog2(MAX_DIMS + 1);
  localparam int unsigned EW    = ndlit_pkg::ExtentW;
  localparam int unsigned FW    = ndlit_pkg::FieldW;

  ndlit_pkg::cfg_t       cfg;
  ndlit_pkg::div_stat_t  div_stat;
  ndlit_pkg::seq_state_e state_q, state_d;

  logic [CalcW-1:0]    rest_q, rest_d;
  logic [CalcW-1:0]    src_q, src_d;
  logic [DimW-1:0]     k_q, k_d;
  logic                last_q, last_d;
  logic                oor_q, oor_d;
  logic                out_valid_q, out_valid_d;
  logic [FW-1:0]       out_src_q;
  logic                out_last_q;
  logic                out_oor_q;

  logic [DimW-1:0]     dims;
  logic [DimW-1:0]     d_sel;
  logic [EW-1:0]       ext_raw;
  logic [EW-1:0]       ext_cur;
  logic [CalcW-1:0]    quotient;
  logic [EW-1:0]       digit;
  logic [CalcW+EW-1:0] prod;
  logic                last_dim;
  logic                in_accept;
  logic                out_free;
  logic                div_start;
  logic                load_out;

  ndlit_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  ndlit_divider #(
    .DW (CalcW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (rest_q),
    .divisor_i   (ext_cur),
    .quotient_o  (quotient),
    .remainder_o (digit),
    .stat_o      (div_stat)
  );

  // dimension count saturates at MAX_DIMS
  always_comb begin
    if (int'(cfg.dim_count) > int'(MAX_DIMS)) begin
      dims = DimW'(MAX_DIMS);
    end else begin
      dims = DimW'(cfg.dim_count);
    end
  end

  // extent of the current step; missing or zero extents act as one
  always_comb begin
    d_sel   = cfg.to_column_major ? k_q : DimW'(dims - k_q - 1'b1);
    ext_raw = EW'(1);
    for (int i = 0; i < ndlit_pkg::ExtentRegs; i++) begin
      if (int'(d_sel) == i) begin
        ext_raw = cfg.extent[i];
      end
    end
    ext_cur = (ext_raw == '0) ? EW'(1) : ext_raw;
  end

  assign prod      = src_q * ext_cur;
  assign last_dim  = (DimW'(k_q + 1'b1) == dims);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ndlit_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (dims == '0) ? ndlit_pkg::ST_DONE : ndlit_pkg::ST_SETUP;
        end
      end
      ndlit_pkg::ST_SETUP: state_d = ndlit_pkg::ST_DIV;
      ndlit_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = last_dim ? ndlit_pkg::ST_DONE : ndlit_pkg::ST_SETUP;
        end
      end
      ndlit_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ndlit_pkg::ST_IDLE;
        end
      end
      default: state_d = ndlit_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ndlit_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      ndlit_pkg::ST_SETUP: div_start     = 1'b1;
      ndlit_pkg::ST_DIV:   ;
      ndlit_pkg::ST_DONE:  load_out      = out_free;
      default: ;
    endcase
  end

  // working registers
  always_comb begin
    rest_d = rest_q;
    src_d  = src_q;
    k_d    = k_q;
    last_d = last_q;
    oor_d  = oor_q;
    if (in_accept) begin
      rest_d = s_axis_tdata[CalcW-1:0];
      src_d  = '0;
      k_d    = '0;
      last_d = (cfg.element_count != '0) &&
               (s_axis_tdata == cfg.element_count - 1'b1);
      oor_d  = (s_axis_tdata >= cfg.element_count);
    end else if ((state_q == ndlit_pkg::ST_DIV) && div_stat.done) begin
      // digit becomes the new least significant place of the source index
      rest_d = quotient;
      src_d  = prod[CalcW-1:0] + CalcW'(digit);
      k_d    = DimW'(k_q + 1'b1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ndlit_pkg::ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    src_q  <= src_d;
    last_q <= last_d;
    oor_q  <= oor_d;
    if (load_out) begin
      out_src_q  <= FW'(src_q);
      out_last_q <= last_q;
      out_oor_q  <= oor_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_src_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_oor_q;

  `ASSERT_AT(a_accept_div_quiet, clk_i, rst_ni, in_accept |-> !div_stat.busy)
  `ASSERT_AT(a_div_busy_in_div, clk_i, rst_ni, div_stat.busy |-> state_q == ndlit_pkg::ST_DIV)
  `ASSERT_AT(a_done_in_div, clk_i, rst_ni, div_stat.done |-> state_q == ndlit_pkg::ST_DIV)
  `ASSERT_AT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ndlit_pkg::ST_DONE))

endmodule

### hw/rtl/ndlit_cfg_regs.sv
// configuration register file of the nd array index transpose block
// depends on ndlit_pkg for the register codes and the cfg_t bundle
module ndlit_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [ndlit_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [ndlit_pkg::CfgDataW-1:0] data_i,
  output ndlit_pkg::cfg_t                cfg_o
);

  ndlit_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (ndlit_pkg::cfg_reg_e'(idx_i))
        ndlit_pkg::REG_DIM_COUNT:
          cfg_d.dim_count = data_i[ndlit_pkg::DimCountW-1:0];
        ndlit_pkg::REG_EXTENT_0:
          cfg_d.extent[0] = data_i[ndlit_pkg::ExtentW-1:0];
        ndlit_pkg::REG_EXTENT_1:
          cfg_d.extent[1] = data_i[ndlit_pkg::ExtentW-1:0];
        ndlit_pkg::REG_EXTENT_2:
          cfg_d.extent[2] = data_i[ndlit_pkg::ExtentW-1:0];
        ndlit_pkg::REG_EXTENT_3:
          cfg_d.extent[3] = data_i[ndlit_pkg::ExtentW-1:0];
        ndlit_pkg::REG_TO_COLUMN_MAJOR:
          cfg_d.to_column_major = data_i[0];
        ndlit_pkg::REG_ELEMENT_COUNT:
          cfg_d.element_count = data_i[ndlit_pkg::FieldW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_count       <= ndlit_pkg::DimCountW'(1);
      for (int i = 0; i < ndlit_pkg::ExtentRegs; i++) begin
        cfg_q.extent[i]     <= ndlit_pkg::ExtentW'(1);
      end
      cfg_q.to_column_major <= 1'b0;
      cfg_q.element_count   <= ndlit_pkg::FieldW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/ndlit_divider.sv
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on ndlit_pkg for the extent width and the div_stat_t status bundle
module ndlit_divider #(
  parameter int unsigned DW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DW-1:0]                 dividend_i,
  input  logic [ndlit_pkg::ExtentW-1:0] divisor_i,
  output logic [DW-1:0]                 quotient_o,
  output logic [ndlit_pkg::ExtentW-1:0] remainder_o,
  output ndlit_pkg::div_stat_t          stat_o
);

  localparam int unsigned CntW = $clog2(DW + 1);
  localparam int unsigned EW   = ndlit_pkg::ExtentW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [EW-1:0]   rem_q, rem_d;
  logic [EW-1:0]   dvs_q, dvs_d;
  logic [EW:0]     trial;
  logic [EW:0]     diff;
  logic            fits;
  logic            busy;

  assign busy  = (cnt_q != '0);
  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(DW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (busy) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
      quo_d  = {quo_q[DW-2:0], fits};
      rem_d  = fits ? diff[EW-1:0] : trial[EW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o.busy = busy;
  assign stat_o.done = done_q;

endmodule

### test/nd_array_layout_index_transpose_unit_tb.sv
// self-checking testbench for the nd array layout index transpose unit
// predicts each source index, last and range flag, and checks the result stream in order
// depends on ndlit_pkg and the nd_array_layout_index_transpose_unit rtl
`timescale 1ns / 100ps

module nd_array_layout_index_transpose_unit_tb;

  localparam int unsigned MaxDims   = 4;
  localparam int unsigned IndexW    = 32;
  localparam logic [ndlit_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned PhaseLen  = 85;

  typedef struct packed {
    logic [ndlit_pkg::FieldW-1:0] source_index;
    logic                         last_element;
    logic                         out_of_range;
  } transposed_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [ndlit_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [ndlit_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [31:0]                    s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;

  // shadow copy of the layout registers
  logic [ndlit_pkg::DimCountW-1:0] layout_dims;
  logic [ndlit_pkg::ExtentW-1:0]   layout_extent [ndlit_pkg::ExtentRegs];
  logic                            layout_col_major;
  logic [ndlit_pkg::FieldW-1:0]    layout_count;

  transposed_t expected_sources [$];
  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent      = 0;
  int unsigned layouts_applied = 0;
  bit          idle_on         = 1'b1;
  int unsigned sink_stall      = 0;
  int unsigned sink_hold       = 0;

  nd_array_layout_index_transpose_unit #(
    .MAX_DIMS   (MaxDims),
    .INDEX_WIDTH(IndexW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [31:0] dest_index
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [31:0] source_index
    .m_axis_tlast (m_axis_tlast),   // last_element
    .m_axis_tuser (m_axis_tuser)    // [0] out_of_range
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // mixed-radix split of the destination index, digits reassembled in reverse order
  function automatic transposed_t transpose_index(input logic [31:0] dest);
    transposed_t res;
    logic [63:0] rest;
    logic [63:0] src;
    logic [63:0] radix;
    int unsigned dims;
    int unsigned d;
    int unsigned k;
    dims = (layout_dims > MaxDims) ? MaxDims : layout_dims;
    rest = {32'd0, dest};
    src  = '0;
    for (k = 0; k < dims; k++) begin
      d = layout_col_major ? k : dims - k - 1;
      radix = (d < ndlit_pkg::ExtentRegs) ? {48'd0, layout_extent[d]} : 64'd1;
      if (radix == 0) radix = 64'd1;
      src  = src * radix + rest % radix;
      rest = rest / radix;
    end
    res.source_index = src[31:0];
    res.last_element = (layout_count != 0) &&
                       ({32'd0, dest} == {32'd0, layout_count} - 64'd1);
    res.out_of_range = (dest >= layout_count);
    return res;
  endfunction

  task automatic write_reg(input logic [ndlit_pkg::CfgIdxW-1:0] idx,
                           input logic [ndlit_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      ndlit_pkg::REG_DIM_COUNT:       layout_dims      = val[ndlit_pkg::DimCountW-1:0];
      ndlit_pkg::REG_EXTENT_0:        layout_extent[0] = val[ndlit_pkg::ExtentW-1:0];
      ndlit_pkg::REG_EXTENT_1:        layout_extent[1] = val[ndlit_pkg::ExtentW-1:0];
      ndlit_pkg::REG_EXTENT_2:        layout_extent[2] = val[ndlit_pkg::ExtentW-1:0];
      ndlit_pkg::REG_EXTENT_3:        layout_extent[3] = val[ndlit_pkg::ExtentW-1:0];
      ndlit_pkg::REG_TO_COLUMN_MAJOR: layout_col_major = val[0];
      ndlit_pkg::REG_ELEMENT_COUNT:   layout_count     = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_layout(input logic [31:0] dims, input logic [31:0] e0,
                              input logic [31:0] e1, input logic [31:0] e2,
                              input logic [31:0] e3, input logic [31:0] col,
                              input logic [31:0] count);
    write_reg(ndlit_pkg::REG_DIM_COUNT, dims);
    write_reg(ndlit_pkg::REG_EXTENT_0, e0);
    write_reg(ndlit_pkg::REG_EXTENT_1, e1);
    write_reg(ndlit_pkg::REG_EXTENT_2, e2);
    write_reg(ndlit_pkg::REG_EXTENT_3, e3);
    write_reg(ndlit_pkg::REG_TO_COLUMN_MAJOR, col);
    write_reg(ndlit_pkg::REG_ELEMENT_COUNT, count);
    layouts_applied++;
  endtask

  task automatic send_index(input logic [31:0] dest);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dest;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    expected_sources.push_back(transpose_index(dest));
    items_sent++;
  endtask

  // stop offering, let every outstanding result arrive, then a short settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_sources.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // result sink: per-transaction stall or a long hold, counted here
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (sink_stall > 0) begin
        m_axis_tready <= 1'b0;
        sink_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    transposed_t exp_res;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sources.size() == 0) begin
          $display("%0t: unexpected result source_index %h last %b oor %b", $time,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
          error_count++;
        end else begin
          exp_res = expected_sources.pop_front();
          if (m_axis_tdata !== exp_res.source_index) begin
            $display("%0t: source_index expected %h actual %h", $time,
                     exp_res.source_index, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== exp_res.last_element) begin
            $display("%0t: last_element expected %b actual %b", $time,
                     exp_res.last_element, m_axis_tlast);
            error_count++;
          end
          if (m_axis_tuser !== exp_res.out_of_range) begin
            $display("%0t: out_of_range expected %b actual %b", $time,
                     exp_res.out_of_range, m_axis_tuser);
            error_count++;
          end
          results_checked++;
        end
        sink_stall = idle_on ? $urandom_range(0, 3) : 0;
      end
    end
  end

  task automatic test_reset_defaults();
    // one dimension of extent one: source always zero, only index zero is in range
    send_index(32'd0);
    send_index(32'd1);
    send_index(32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_direction();
    apply_layout(3, 2, 3, 4, 1, 1, 24);
    send_index(32'd0);
    send_index(32'd7);
    send_index(32'd23);
    send_index(32'd24);
    wait_idle();
    write_reg(ndlit_pkg::REG_TO_COLUMN_MAJOR, 32'd0);
    send_index(32'd5);
    send_index(32'd23);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    apply_layout(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 32'hFFFF_FFFF);
    send_index(32'hFFFF_FFFE);
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0001);
    wait_idle();
  endtask

  task automatic test_zero_settings();
    // empty array: nothing is last, everything out of range
    apply_layout(1, 1, 1, 1, 1, 0, 0);
    send_index(32'd0);
    wait_idle();
    // zero extent behaves as one
    apply_layout(2, 0, 5, 1, 1, 1, 5);
    send_index(32'd13);
    send_index(32'd3);
    wait_idle();
    // no dimensions: source index is zero
    write_reg(ndlit_pkg::REG_DIM_COUNT, 32'd0);
    send_index(32'd12345);
    wait_idle();
  endtask

  task automatic test_dim_saturation();
    apply_layout(7, 5, 6, 7, 8, 0, 1680);
    send_index(32'd1000);
    send_index(32'd1679);
    wait_idle();
    // unmapped register index must leave the layout alone
    write_reg(RegUnused, 32'd3);
    send_index(32'd77);
    wait_idle();
  endtask

  task automatic test_backpressure();
    int unsigned n;
    apply_layout(2, 3, 5, 1, 1, 0, 15);
    // sink holds off while items keep coming, so the input side must stall
    sink_hold = 300;
    for (n = 0; n < 8; n++) send_index($urandom_range(0, 15));
    wait_idle();
  endtask

  task automatic test_random_layouts();
    int unsigned phase;
    int unsigned n;
    int unsigned sel;
    int unsigned d;
    logic [31:0] dims;
    logic [31:0] ext [ndlit_pkg::ExtentRegs];
    logic [63:0] prod;
    logic [31:0] count;
    logic [31:0] dest;
    for (phase = 0; phase < NumPhases; phase++) begin
      idle_on = (phase % 3 != 2);
      if (phase == 0) begin
        dims = 4;
        for (d = 0; d < ndlit_pkg::ExtentRegs; d++) ext[d] = 32'h0000_FFFF;
      end else begin
        sel  = $urandom_range(0, 9);
        dims = (sel == 0) ? 32'd0 : (sel == 1) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        for (d = 0; d < ndlit_pkg::ExtentRegs; d++) begin
          sel = $urandom_range(0, 9);
          // upper data bits random too: only the low bits should land in the register
          ext[d] = (sel == 0) ? {16'($urandom_range(0, 65535)), 16'd0} :
                   (sel == 1) ? $urandom : $urandom_range(1, 12);
        end
      end
      prod = 64'd1;
      for (d = 0; d < dims && d < MaxDims; d++) begin
        if (ext[d][15:0] != 0) prod = prod * ext[d][15:0];
      end
      count = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      sel = $urandom_range(0, 7);
      if (sel == 0) count = $urandom;
      else if (sel == 1) count = 32'd0;
      apply_layout(dims, ext[0], ext[1], ext[2], ext[3], $urandom, count);
      for (n = 0; n < PhaseLen; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 7 && count != 0) dest = $urandom_range(count - 1, 0);
        else if (sel == 7) dest = count - ($urandom_range(0, 1));
        else dest = $urandom;
        send_index(dest);
      end
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    layout_dims      = 3'd1;
    layout_extent[0] = 16'd1;
    layout_extent[1] = 16'd1;
    layout_extent[2] = 16'd1;
    layout_extent[3] = 16'd1;
    layout_col_major = 1'b0;
    layout_count     = 32'd1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_direction();
    test_field_extremes();
    test_zero_settings();
    test_dim_saturation();
    test_backpressure();
    test_random_layouts();

    wait_idle();
    repeat (150) @(posedge clk_i);
    $display("%0d transactions sent over %0d layout settings, %0d results checked",
             items_sent, layouts_applied, results_checked);
    $display("layouts covered both directions, saturated and zero dimensions, zero extents");
    if (error_count == 0 && expected_sources.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
